[hdl/deq_pkg.sv]
package deq_pkg;

    localparam int ValueW = 32;

    typedef logic signed [ValueW-1:0] value_t;

    // Operation carried on the input beat.
    typedef enum logic [1:0] {
        KIND_PUSH_BACK  = 2'd0,
        KIND_PUSH_FRONT = 2'd1,
        KIND_POP_BACK   = 2'd2,
        KIND_POP_FRONT  = 2'd3
    } kind_t;

    // Outcome reported with every result beat.
    typedef enum logic [1:0] {
        STATUS_DONE  = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    // Value returned by a pop on an empty queue.
    localparam value_t EMPTY_POP_VALUE = '1;

    // Operation broadcast to every cell; each strobe is already qualified
    // by the occupancy so at most one is high.
    typedef struct packed {
        logic   push_front;
        logic   push_back;
        logic   pop_front;
        logic   pop_back;
        value_t push_value;
    } cell_ctrl_t;

    // What a cell shows to its neighbours.
    typedef struct packed {
        logic   valid;
        value_t value;
    } cell_link_t;

endpackage

[hdl/deq_cell.sv]
module deq_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  deq_pkg::cell_ctrl_t ctrl,
    input  deq_pkg::cell_link_t from_left,
    input  deq_pkg::cell_link_t from_right,
    output deq_pkg::cell_link_t link,
    output deq_pkg::value_t     back_tap
);

    logic            valid_reg;
    logic            valid_next;
    deq_pkg::value_t value_reg;
    deq_pkg::value_t value_next;
    logic            is_back;

    // The queue always fills a prefix of the row, so this cell is the back
    // when it holds an entry and its right neighbour does not.
    assign is_back = valid_reg && !from_right.valid;

    always_comb
    begin
        valid_next = valid_reg;
        value_next = value_reg;
        if (ctrl.push_front)
        begin
            valid_next = from_left.valid;
            value_next = from_left.value;
        end
        else if (ctrl.pop_front)
        begin
            valid_next = from_right.valid;
            value_next = from_right.value;
        end
        else if (ctrl.push_back)
        begin
            if (!valid_reg && from_left.valid)
            begin
                valid_next = 1'b1;
                value_next = ctrl.push_value;
            end
        end
        else if (ctrl.pop_back)
        begin
            if (is_back)
            begin
                valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign link.valid = valid_reg;
    assign link.value = value_reg;
    assign back_tap   = is_back ? value_reg : '0;

endmodule

[hdl/double_ended_queue.sv]
// Bounded double-ended queue of signed 32-bit values, built as a row of
// DEPTH cells. The front of the queue always sits in cell 0 and the entries
// fill a prefix of the row: a push or pop at the front shifts every cell by
// one place towards or away from its neighbour, while a push or pop at the
// back changes only the cell at the boundary of the filled prefix.
// Input channel (s_*): one beat per operation, the operation in s_tuser and
// the value to push in s_tdata (ignored by pops).
// Output channel (m_*): exactly one beat per input beat, in order, carrying
// the status in m_tuser and the popped value with the new occupancy in
// m_tdata. A pop on an empty queue returns all ones with status empty; a push
// on a full queue is dropped with status full and leaves the queue as it was.
// The result beat of an accepted input beat is registered, and the block
// takes one beat per cycle while the receiver does not stall: every cell
// updates in the same edge, and the back value is picked from the cells by
// a one-hot select into the output register.
// The result sits in a single output register. While the receiver stalls
// with a result pending, s_tready is low; it rises again in the cycle in
// which the pending beat is taken, so no cycle is lost when m_tready is high.
// Reset empties the queue at once by clearing the cell valid bits and the
// occupancy count; the block is ready for a beat in the first cycle after.
module double_ended_queue #(
    parameter  int DEPTH  = 64,
    localparam int OccW   = $clog2(DEPTH + 1),
    localparam int MDataW = ((deq_pkg::ValueW + OccW + 7) / 8) * 8
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [deq_pkg::ValueW-1:0]   s_tdata,  // push_value
    input  logic [1:0]                   s_tuser,  // kind
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [MDataW-1:0]            m_tdata,  // pop_value, occupancy, zero fill
    output logic [1:0]                   m_tuser   // status
);

    localparam logic [OccW-1:0] FullCount = OccW'(DEPTH);

    deq_pkg::kind_t       kind;
    deq_pkg::cell_ctrl_t  ctrl;
    deq_pkg::cell_link_t  links [DEPTH];
    deq_pkg::value_t      taps  [DEPTH];
    deq_pkg::cell_link_t  head_feed;
    deq_pkg::cell_link_t  tail_feed;
    deq_pkg::value_t      back_value;
    logic [DEPTH-1:0]     valid_vec;

    logic                 s_accept;
    logic                 is_full;
    logic                 is_empty;

    logic [OccW-1:0]      count_reg;
    logic [OccW-1:0]      count_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    deq_pkg::status_t     status_reg;
    deq_pkg::status_t     status_next;
    deq_pkg::value_t      pop_value_reg;
    deq_pkg::value_t      pop_value_next;

    assign s_tready = !out_valid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;
    assign kind     = deq_pkg::kind_t'(s_tuser);
    assign is_full  = (count_reg == FullCount);
    assign is_empty = (count_reg == '0);

    // Cell 0 sees a permanently valid left neighbour carrying the pushed
    // value; the last cell sees an empty right neighbour.
    assign head_feed.valid = 1'b1;
    assign head_feed.value = s_tdata;
    assign tail_feed.valid = 1'b0;
    assign tail_feed.value = '0;

    always_comb
    begin
        ctrl.push_value = s_tdata;
        ctrl.push_front = 1'b0;
        ctrl.push_back  = 1'b0;
        ctrl.pop_front  = 1'b0;
        ctrl.pop_back   = 1'b0;
        count_next      = count_reg;
        status_next     = deq_pkg::STATUS_DONE;
        pop_value_next  = '0;
        if (s_accept)
        begin
            unique case (kind) inside
                deq_pkg::KIND_PUSH_BACK, deq_pkg::KIND_PUSH_FRONT:
                begin
                    if (is_full)
                    begin
                        status_next = deq_pkg::STATUS_FULL;
                    end
                    else
                    begin
                        ctrl.push_back  = (kind == deq_pkg::KIND_PUSH_BACK);
                        ctrl.push_front = (kind == deq_pkg::KIND_PUSH_FRONT);
                        count_next      = count_reg + 1'b1;
                    end
                end
                deq_pkg::KIND_POP_BACK, deq_pkg::KIND_POP_FRONT:
                begin
                    if (is_empty)
                    begin
                        status_next    = deq_pkg::STATUS_EMPTY;
                        pop_value_next = deq_pkg::EMPTY_POP_VALUE;
                    end
                    else
                    begin
                        ctrl.pop_back  = (kind == deq_pkg::KIND_POP_BACK);
                        ctrl.pop_front = (kind == deq_pkg::KIND_POP_FRONT);
                        count_next     = count_reg - 1'b1;
                        pop_value_next = (kind == deq_pkg::KIND_POP_FRONT) ?
                                         links[0].value : back_value;
                    end
                end
                default:
                begin
                    status_next = deq_pkg::STATUS_DONE;
                end
            endcase
        end
    end

    // Only the back cell drives a non-zero tap, so an OR gathers its value.
    always_comb
    begin
        back_value = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            back_value = back_value | taps[i];
        end
    end

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++)
        begin : g_cell
            deq_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl),
                .from_left  ((g == 0) ? head_feed : links[(g == 0) ? 0 : g - 1]),
                .from_right ((g == DEPTH - 1) ? tail_feed
                                              : links[(g == DEPTH - 1) ? g : g + 1]),
                .link       (links[g]),
                .back_tap   (taps[g])
            );
            assign valid_vec[g] = links[g].valid;
        end
    endgenerate

    // A new result replaces the pending one whenever a beat is accepted;
    // otherwise the pending one clears once the receiver takes it.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s_accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            status_reg    <= status_next;
            pop_value_reg <= pop_value_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = MDataW'({count_reg, pop_value_reg});

`ifndef NO_ASSERTIONS
    // The filled cells always match the occupancy count.
    a_count_matches_cells: assert property (
        @(posedge clk) disable iff (!rst_n)
        $countones(valid_vec) == int'(count_reg))
        else $error("cell valid bits disagree with occupancy count");

    // The occupancy never exceeds the number of cells.
    a_count_bounded: assert property (
        @(posedge clk) disable iff (!rst_n)
        count_reg <= FullCount)
        else $error("occupancy count beyond depth");

    // A pop on an empty queue reports empty with an all-ones value.
    a_pop_empty: assert property (
        @(posedge clk) disable iff (!rst_n)
        s_accept && is_empty &&
        (kind == deq_pkg::KIND_POP_BACK || kind == deq_pkg::KIND_POP_FRONT)
        |=> status_reg == deq_pkg::STATUS_EMPTY && pop_value_reg == deq_pkg::EMPTY_POP_VALUE)
        else $error("pop on empty queue not flagged");

    // A push on a full queue leaves the count unchanged and is flagged.
    a_push_full: assert property (
        @(posedge clk) disable iff (!rst_n)
        s_accept && is_full &&
        (kind == deq_pkg::KIND_PUSH_BACK || kind == deq_pkg::KIND_PUSH_FRONT)
        |=> status_reg == deq_pkg::STATUS_FULL && $stable(count_reg))
        else $error("push on full queue not dropped");

    // No beat is accepted while an untaken result is pending.
    a_no_overwrite: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid_reg && !m_tready |-> !s_accept)
        else $error("result overwritten while stalled");
`endif

endmodule
